// ===== src/erv_pkg.sv =====
// ----------------------------------------------------------------------------
// erv_pkg: shared types and constants for the roll-pitch-yaw vector rotator
// Field widths, register map, mode codes, sine coefficients and stage counts.
// ----------------------------------------------------------------------------
package erv_pkg;

   // field widths (fixed by the item format)
   localparam int VEC_W = 24;
   localparam int ANG_W = 16;
   localparam int TERM_W = 32;   // matrix term, Q30 within [-2^30, 2^30]

   typedef logic signed [VEC_W-1:0]  vec_type;
   typedef logic signed [ANG_W-1:0]  ang_type;
   typedef logic signed [15:0]       q15_type;
   typedef logic signed [TERM_W-1:0] term_type;

   // quarter turn in the binary angle
   localparam ang_type ANG_QUARTER = ang_type'(1 << (ANG_W - 2));

   typedef struct packed {
      vec_type    vec_x;
      vec_type    vec_y;
      vec_type    vec_z;
      ang_type    roll;
      ang_type    pitch;
      ang_type    yaw;
      logic       last_in;
   } req_type;

   typedef struct packed {
      vec_type    out_x;
      vec_type    out_y;
      vec_type    out_z;
      logic       last_out;
   } rsp_type;

   // mode register codes; the unused code acts as per-item
   typedef enum logic [1:0] {
      MODE_ITEM   = 2'd0,
      MODE_ANGLES = 2'd1,
      MODE_VECTOR = 2'd2
   } mode_type;

   // register indexes (byte address = 4 * index)
   localparam logic [2:0] REG_MODE    = 3'd0;
   localparam logic [2:0] REG_ROLL    = 3'd1;
   localparam logic [2:0] REG_PITCH   = 3'd2;
   localparam logic [2:0] REG_YAW     = 3'd3;
   localparam logic [2:0] REG_FIXED_X = 3'd4;
   localparam logic [2:0] REG_FIXED_Y = 3'd5;
   localparam logic [2:0] REG_FIXED_Z = 3'd6;

   // Taylor coefficients of sin(pi/2*u), Q30, highest order first
   localparam logic [30:0] SINE_COEF [6] = '{
      31'd3864, 31'd172272, 31'd5026995,
      31'd85569306, 31'd693598668, 31'd1686629713
   };

   // stage counts
   localparam int SIN_LAT  = 9;
   localparam int MAT_LAT  = 3;
   localparam int MAC_LAT  = 3;
   localparam int VEC_LAT  = SIN_LAT + MAT_LAT;
   localparam int PIPE_LAT = SIN_LAT + MAT_LAT + MAC_LAT;

   // result buffer
   localparam int FIFO_DEPTH = 32;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

endpackage

// ===== src/euler_rpy_vector_rotate.sv =====
// ----------------------------------------------------------------------------
// euler_rpy_vector_rotate: Z-Y-X roll-pitch-yaw rotation of a 3-vector
// Top level: register port, item intake, pipeline and result buffer.
// ----------------------------------------------------------------------------
// The block takes one item per clock and returns one rotated vector for each,
// in order. An item passes through the pipeline (intake register, 9-stage
// sine units, 3-stage matrix term unit, 3-stage multiply-accumulate) before it
// lands in a 32-entry result buffer. The buffer is read through a
// registered output stage, from which each result is offered.
// The pipeline never stalls; intake stops only when 32 items are outstanding,
// so with rsp_ready held high the block sustains one item per cycle. Mode 1
// takes the angles from the fixed angle registers and mode 2 the vector from
// the fixed vector registers; write the registers only while no item is
// outstanding.
module euler_rpy_vector_rotate import erv_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   // configuration registers
   logic [1:0] mode_ff;
   ang_type    froll_ff, fpitch_ff, fyaw_ff;
   vec_type    fx_ff, fy_ff, fz_ff;
   logic [2:0] reg_idx;
   logic       cfg_wr;

   // intake
   logic       accept;
   logic       ent_v_ff;
   ang_type    ent_roll_ff, ent_pitch_ff, ent_yaw_ff;
   vec_type    ent_x_ff, ent_y_ff, ent_z_ff;
   logic       ent_last_ff;

   // pipeline
   q15_type    sr, cr, sp, cp, sy, cy;
   term_type   m [9];
   vec_type    vx_d_ff [VEC_LAT];
   vec_type    vy_d_ff [VEC_LAT];
   vec_type    vz_d_ff [VEC_LAT];
   logic       last_d_ff  [PIPE_LAT];
   logic       valid_d_ff [PIPE_LAT];
   vec_type    ox, oy, oz;

   // result buffer and outstanding count
   rsp_type            fifo_mem [FIFO_DEPTH];
   logic [FIFO_AW:0]   wptr_ff, rptr_ff;
   logic [FIFO_AW:0]   cnt_ff;
   rsp_type            rd_data_ff;
   logic               rd_v_ff;
   logic               pipe_out_v;
   logic               deliver;
   logic               fetch;

   // register port
   assign pready  = 1'b1;
   assign reg_idx = paddr[4:2];
   assign cfg_wr  = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_ITEM;
         froll_ff  <= '0;
         fpitch_ff <= '0;
         fyaw_ff   <= '0;
         fx_ff     <= '0;
         fy_ff     <= '0;
         fz_ff     <= '0;
      end else if (cfg_wr) begin
         unique case (reg_idx)
            REG_MODE:    mode_ff   <= pwdata[1:0];
            REG_ROLL:    froll_ff  <= pwdata[ANG_W-1:0];
            REG_PITCH:   fpitch_ff <= pwdata[ANG_W-1:0];
            REG_YAW:     fyaw_ff   <= pwdata[ANG_W-1:0];
            REG_FIXED_X: fx_ff     <= pwdata[VEC_W-1:0];
            REG_FIXED_Y: fy_ff     <= pwdata[VEC_W-1:0];
            REG_FIXED_Z: fz_ff     <= pwdata[VEC_W-1:0];
            default: ;
         endcase
      end
   end

   // read back
   always_comb begin
      unique case (reg_idx)
         REG_MODE:    prdata = {30'b0, mode_ff};
         REG_ROLL:    prdata = {{(32-ANG_W){1'b0}}, froll_ff};
         REG_PITCH:   prdata = {{(32-ANG_W){1'b0}}, fpitch_ff};
         REG_YAW:     prdata = {{(32-ANG_W){1'b0}}, fyaw_ff};
         REG_FIXED_X: prdata = {{(32-VEC_W){1'b0}}, fx_ff};
         REG_FIXED_Y: prdata = {{(32-VEC_W){1'b0}}, fy_ff};
         REG_FIXED_Z: prdata = {{(32-VEC_W){1'b0}}, fz_ff};
         default:     prdata = '0;
      endcase
   end

   // intake: pick angle and vector sources by mode
   assign req_ready = (cnt_ff < (FIFO_AW+1)'(FIFO_DEPTH));
   assign accept    = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         ent_v_ff <= 1'b0;
      end else begin
         ent_v_ff <= accept;
      end
   end

   // the spare mode code falls through to per-item sources
   always_ff @(posedge clock) begin
      ent_roll_ff  <= (mode_ff == MODE_ANGLES) ? froll_ff  : req_data.roll;
      ent_pitch_ff <= (mode_ff == MODE_ANGLES) ? fpitch_ff : req_data.pitch;
      ent_yaw_ff   <= (mode_ff == MODE_ANGLES) ? fyaw_ff   : req_data.yaw;
      ent_x_ff     <= (mode_ff == MODE_VECTOR) ? fx_ff     : req_data.vec_x;
      ent_y_ff     <= (mode_ff == MODE_VECTOR) ? fy_ff     : req_data.vec_y;
      ent_z_ff     <= (mode_ff == MODE_VECTOR) ? fz_ff     : req_data.vec_z;
      ent_last_ff  <= req_data.last_in;
   end

   // sines and cosines; cosine is the sine a quarter turn ahead
   erv_sine u_sin_r (.clock(clock), .angle(ent_roll_ff), .sine(sr));
   erv_sine u_cos_r (.clock(clock), .angle(ANG_W'(ent_roll_ff + ANG_QUARTER)), .sine(cr));
   erv_sine u_sin_p (.clock(clock), .angle(ent_pitch_ff), .sine(sp));
   erv_sine u_cos_p (.clock(clock), .angle(ANG_W'(ent_pitch_ff + ANG_QUARTER)), .sine(cp));
   erv_sine u_sin_y (.clock(clock), .angle(ent_yaw_ff), .sine(sy));
   erv_sine u_cos_y (.clock(clock), .angle(ANG_W'(ent_yaw_ff + ANG_QUARTER)), .sine(cy));

   erv_matrix u_matrix (
      .clock(clock),
      .sr(sr), .cr(cr), .sp(sp), .cp(cp), .sy(sy), .cy(cy),
      .m(m)
   );

   // vector and flag travel beside the angle path
   always_ff @(posedge clock) begin
      vx_d_ff[0]   <= ent_x_ff;
      vy_d_ff[0]   <= ent_y_ff;
      vz_d_ff[0]   <= ent_z_ff;
      last_d_ff[0] <= ent_last_ff;
      for (int i = 1; i < VEC_LAT; i++) begin
         vx_d_ff[i] <= vx_d_ff[i-1];
         vy_d_ff[i] <= vy_d_ff[i-1];
         vz_d_ff[i] <= vz_d_ff[i-1];
      end
      for (int i = 1; i < PIPE_LAT; i++) begin
         last_d_ff[i] <= last_d_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PIPE_LAT; i++) begin
            valid_d_ff[i] <= 1'b0;
         end
      end else begin
         valid_d_ff[0] <= ent_v_ff;
         for (int i = 1; i < PIPE_LAT; i++) begin
            valid_d_ff[i] <= valid_d_ff[i-1];
         end
      end
   end

   erv_mac u_mac (
      .clock(clock),
      .vx(vx_d_ff[VEC_LAT-1]), .vy(vy_d_ff[VEC_LAT-1]), .vz(vz_d_ff[VEC_LAT-1]),
      .m(m),
      .ox(ox), .oy(oy), .oz(oz)
   );

   // result buffer with a registered read port feeding the output
   assign pipe_out_v = valid_d_ff[PIPE_LAT-1];
   assign rsp_valid  = rd_v_ff;
   assign rsp_data   = rd_data_ff;
   assign deliver    = rsp_valid && rsp_ready;
   // refill the output register when it is empty or being taken
   assign fetch      = (wptr_ff != rptr_ff) && (!rd_v_ff || rsp_ready);

   always_ff @(posedge clock) begin
      if (pipe_out_v) begin
         fifo_mem[wptr_ff[FIFO_AW-1:0]] <= '{out_x: ox, out_y: oy, out_z: oz,
                                             last_out: last_d_ff[PIPE_LAT-1]};
      end
      if (fetch) begin
         rd_data_ff <= fifo_mem[rptr_ff[FIFO_AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
         rd_v_ff <= 1'b0;
      end else begin
         if (pipe_out_v) begin
            wptr_ff <= wptr_ff + 1'b1;
         end
         if (fetch) begin
            rptr_ff <= rptr_ff + 1'b1;
            rd_v_ff <= 1'b1;
         end else if (deliver) begin
            rd_v_ff <= 1'b0;
         end
         case ({accept, deliver})
            2'b10:   cnt_ff <= cnt_ff + 1'b1;
            2'b01:   cnt_ff <= cnt_ff - 1'b1;
            default: ;
         endcase
      end
   end

   // checks
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (FIFO_AW+1)'(FIFO_DEPTH))
      else $error("outstanding count above buffer depth");

   a_fifo_in_cnt: assert property (@(posedge clock) disable iff (reset)
      (wptr_ff - rptr_ff) <= cnt_ff)
      else $error("buffered results exceed outstanding items");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      pipe_out_v |-> ((wptr_ff - rptr_ff) < (FIFO_AW+1)'(FIFO_DEPTH)))
      else $error("result written into a full buffer");

   a_intake: assert property (@(posedge clock) disable iff (reset)
      accept |=> ent_v_ff)
      else $error("accepted item missing from intake stage");

endmodule

// ===== src/erv_sine.sv =====
// ----------------------------------------------------------------------------
// erv_sine: pipelined Q15 sine of a binary angle
// Quadrant fold, squared argument, five Horner steps and the final product,
// one multiplier per product stage, then round, saturate and sign.
// ----------------------------------------------------------------------------
module erv_sine import erv_pkg::*; (
   input  logic    clock,
   input  ang_type angle,
   output q15_type sine
);

   logic [1:0]  quad;
   logic [13:0] frac;
   logic [14:0] uk_in;

   logic [14:0] uk_ff   [7];
   logic        neg_ff  [8];
   logic [28:0] ksq_ff  [5];
   logic [59:0] t_ff    [5];
   logic [30:0] p_c     [6];
   logic [45:0] f_ff;
   logic [17:0] rnd_c;
   logic [14:0] mag_c;
   q15_type     sine_ff;

   // fold into the first quadrant; u = uk * 2^16 in Q30
   always_comb begin
      quad  = angle[ANG_W-1:ANG_W-2];
      frac  = angle[ANG_W-3:0];
      uk_in = quad[0] ? (15'(1 << 14) - {1'b0, frac}) : {1'b0, frac};
   end

   // Horner operands: p_i = C_i - (p_(i-1) * u^2 >> 30)
   always_comb begin
      p_c[0] = SINE_COEF[0];
      for (int i = 1; i < 6; i++) begin
         p_c[i] = SINE_COEF[i] - t_ff[i-1][58:28];
      end
   end

   // final rounding to Q15 with saturation
   always_comb begin
      rnd_c = 18'(({1'b0, f_ff[45:14]} + 33'(1 << 14)) >> 15);
      mag_c = (rnd_c > 18'd32767) ? 15'h7FFF : rnd_c[14:0];
   end

   always_ff @(posedge clock) begin
      uk_ff[0]  <= uk_in;
      neg_ff[0] <= quad[1];
      for (int i = 1; i < 7; i++) begin
         uk_ff[i] <= uk_ff[i-1];
      end
      for (int i = 1; i < 8; i++) begin
         neg_ff[i] <= neg_ff[i-1];
      end
      // u^2 >> 30 equals uk^2 * 4, so the 4 folds into the shifts below
      ksq_ff[0] <= 29'(30'(uk_ff[0]) * 30'(uk_ff[0]));
      for (int i = 1; i < 5; i++) begin
         ksq_ff[i] <= ksq_ff[i-1];
      end
      for (int i = 0; i < 5; i++) begin
         t_ff[i] <= 60'(p_c[i]) * 60'(ksq_ff[i]);
      end
      f_ff    <= 46'(p_c[5]) * 46'(uk_ff[6]);
      sine_ff <= neg_ff[7] ? -$signed({1'b0, mag_c}) : $signed({1'b0, mag_c});
   end

   assign sine = sine_ff;

endmodule

// ===== src/erv_matrix.sv =====
// ----------------------------------------------------------------------------
// erv_matrix: rotation matrix terms from the six sines and cosines
// Pair products, then triple products, then combine, round and clamp to Q30.
// ----------------------------------------------------------------------------
module erv_matrix import erv_pkg::*; (
   input  logic     clock,
   input  q15_type  sr,
   input  q15_type  cr,
   input  q15_type  sp,
   input  q15_type  cp,
   input  q15_type  sy,
   input  q15_type  cy,
   output term_type m [9]
);

   // stage 1
   logic signed [31:0] srsp_ff, crsp_ff;
   logic signed [31:0] cpcy_ff, crsy_ff, srsy_ff, cpsy_ff;
   logic signed [31:0] crcy_ff, srcy_ff, srcp_ff, crcp_ff;
   q15_type            sp1_ff, sy1_ff, cy1_ff;
   // stage 2
   logic signed [47:0] t1_ff, t2_ff, t4_ff, t5_ff;
   logic signed [31:0] cpcy2_ff, crsy2_ff, srsy2_ff, cpsy2_ff;
   logic signed [31:0] crcy2_ff, srcy2_ff, srcp2_ff, crcp2_ff;
   q15_type            sp2_ff;
   // stage 3
   term_type           m_ff [9];

   // Q45 to Q30 with round half up and clamp to +-2^30
   function automatic term_type erv_term(input logic signed [48:0] v);
      logic signed [48:0] sum;
      logic signed [33:0] sh;
      begin
         sum = v + 49'sd16384;
         sh  = 34'(sum >>> 15);
         if (sh > 34'sd1073741824) begin
            erv_term = 32'sd1073741824;
         end else if (sh < -34'sd1073741824) begin
            erv_term = -32'sd1073741824;
         end else begin
            erv_term = 32'(sh);
         end
      end
   endfunction

   always_ff @(posedge clock) begin
      // pair products
      srsp_ff <= 32'(sr) * 32'(sp);
      crsp_ff <= 32'(cr) * 32'(sp);
      cpcy_ff <= 32'(cp) * 32'(cy);
      crsy_ff <= 32'(cr) * 32'(sy);
      srsy_ff <= 32'(sr) * 32'(sy);
      cpsy_ff <= 32'(cp) * 32'(sy);
      crcy_ff <= 32'(cr) * 32'(cy);
      srcy_ff <= 32'(sr) * 32'(cy);
      srcp_ff <= 32'(sr) * 32'(cp);
      crcp_ff <= 32'(cr) * 32'(cp);
      sp1_ff  <= sp;
      sy1_ff  <= sy;
      cy1_ff  <= cy;

      // triple products
      t1_ff    <= 48'(srsp_ff) * 48'(cy1_ff);
      t2_ff    <= 48'(crsp_ff) * 48'(cy1_ff);
      t4_ff    <= 48'(srsp_ff) * 48'(sy1_ff);
      t5_ff    <= 48'(crsp_ff) * 48'(sy1_ff);
      cpcy2_ff <= cpcy_ff;
      crsy2_ff <= crsy_ff;
      srsy2_ff <= srsy_ff;
      cpsy2_ff <= cpsy_ff;
      crcy2_ff <= crcy_ff;
      srcy2_ff <= srcy_ff;
      srcp2_ff <= srcp_ff;
      crcp2_ff <= crcp_ff;
      sp2_ff   <= sp1_ff;

      // combine; plain pair terms are exact in Q30 and never clip
      m_ff[0] <= cpcy2_ff;
      m_ff[1] <= erv_term(49'(t1_ff) - (49'(crsy2_ff) <<< 15));
      m_ff[2] <= erv_term(49'(t2_ff) + (49'(srsy2_ff) <<< 15));
      m_ff[3] <= cpsy2_ff;
      m_ff[4] <= erv_term(49'(t4_ff) + (49'(crcy2_ff) <<< 15));
      m_ff[5] <= erv_term(49'(t5_ff) - (49'(srcy2_ff) <<< 15));
      m_ff[6] <= -(32'(sp2_ff) <<< 15);
      m_ff[7] <= srcp2_ff;
      m_ff[8] <= crcp2_ff;
   end

   assign m = m_ff;

endmodule

// ===== src/erv_mac.sv =====
// ----------------------------------------------------------------------------
// erv_mac: matrix-vector product
// Nine products, three row sums, then round to integer and saturate.
// ----------------------------------------------------------------------------
module erv_mac import erv_pkg::*; (
   input  logic     clock,
   input  vec_type  vx,
   input  vec_type  vy,
   input  vec_type  vz,
   input  term_type m [9],
   output vec_type  ox,
   output vec_type  oy,
   output vec_type  oz
);

   localparam logic signed [57:0] VMAX = 58'((1 << (VEC_W - 1)) - 1);
   localparam logic signed [57:0] VMIN = -VMAX - 58'sd1;

   vec_type            v_c    [3];
   logic signed [55:0] prod_ff [9];
   logic signed [57:0] acc_ff  [3];
   logic signed [57:0] rnd_c   [3];
   vec_type            res_ff  [3];

   assign v_c[0] = vx;
   assign v_c[1] = vy;
   assign v_c[2] = vz;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         rnd_c[k] = (acc_ff[k] + 58'sd536870912) >>> 30;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 9; i++) begin
         prod_ff[i] <= 56'(v_c[i % 3]) * 56'(m[i]);
      end
      for (int k = 0; k < 3; k++) begin
         acc_ff[k] <= 58'(prod_ff[3*k]) + 58'(prod_ff[3*k+1]) + 58'(prod_ff[3*k+2]);
         if (rnd_c[k] > VMAX) begin
            res_ff[k] <= VEC_W'(VMAX);
         end else if (rnd_c[k] < VMIN) begin
            res_ff[k] <= VEC_W'(VMIN);
         end else begin
            res_ff[k] <= VEC_W'(rnd_c[k]);
         end
      end
   end

   assign ox = res_ff[0];
   assign oy = res_ff[1];
   assign oz = res_ff[2];

endmodule
